FILE: rtl/ihpq_pkg.sv
// Shared types, codes and helpers of the indexed max-heap priority queue.
package ihpq_pkg;

   localparam int SLOT_COUNT = 256;
   localparam int POS_BITS   = 8;
   localparam int CNT_BITS   = 9;
   localparam int ID_BITS    = 8;
   localparam int KEY_BITS   = 8;

   typedef enum logic [2:0] {
      OP_INSERT      = 3'd0,
      OP_INSERT_LAZY = 3'd1,
      OP_BUILD       = 3'd2,
      OP_UPDATE      = 3'd3,
      OP_ERASE       = 3'd4,
      OP_ERASE_LAZY  = 3'd5,
      OP_POP         = 3'd6,
      OP_PEEK        = 3'd7
   } opcode_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_EMPTY   = 3'd1,
      ST_FULL    = 3'd2,
      ST_ABSENT  = 3'd3,
      ST_PRESENT = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_LOOKUP,
      S_TOP,
      S_MOVE_LD,
      S_UPD_LD,
      S_BUILD,
      S_SK_LD,
      S_SK_L,
      S_SK_R,
      S_SK_C,
      S_RISE,
      S_RISE_C,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [ID_BITS-1:0]  id;
      logic [KEY_BITS-1:0] deg;
   } slot_type;

   // which member of a family ranks first
   typedef enum logic [1:0] {
      PICK_SELF  = 2'd0,
      PICK_LEFT  = 2'd1,
      PICK_RIGHT = 2'd2
   } pick_type;

   typedef struct packed {
      slot_type self;
      slot_type left;
      slot_type right;
      logic     left_ok;
      logic     right_ok;
   } family_type;

   // larger degree first, larger id breaks ties
   function automatic logic ranks_above(slot_type a, slot_type b);
      logic res;
      if (a.deg == b.deg) res = a.id > b.id;
      else res = a.deg > b.deg;
      return res;
   endfunction

endpackage

FILE: rtl/ihpq_rank.sv
// Shared compare unit: picks the highest-ranked member of a heap family.
module ihpq_rank (
   input  ihpq_pkg::family_type fam,
   output ihpq_pkg::pick_type   pick
);

   ihpq_pkg::slot_type after_left;
   logic               take_left;

   // left child against the parent, then right child against the winner
   always_comb begin
      take_left  = fam.left_ok && ihpq_pkg::ranks_above(fam.left, fam.self);
      after_left = take_left ? fam.left : fam.self;
      if (fam.right_ok && ihpq_pkg::ranks_above(fam.right, after_left)) begin
         pick = ihpq_pkg::PICK_RIGHT;
      end else if (take_left) begin
         pick = ihpq_pkg::PICK_LEFT;
      end else begin
         pick = ihpq_pkg::PICK_SELF;
      end
   end

endmodule

FILE: rtl/indexed_max_heap_priority_queue_unit.sv
// Indexed binary max-heap priority queue: sequencer, heap memory and id position map.
// One request is handled at a time: req_tready is high only in idle, and a new request is taken
// only after the previous response has been placed in the output register.
// Sifts walk down or up the heap over at most 8 levels; build sinks every slot in turn,
// from the last one down to the root.
// Reset clears the entry count and presence flags; the slot memories need no clearing.
module indexed_max_heap_priority_queue_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // opcode[2:0], vertex_id[10:3], degree[18:11], zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // top_id[7:0], top_degree[15:8], entry_count[24:16],
                                    // status[27:25], zero
);

   localparam int PB = ihpq_pkg::POS_BITS;
   localparam int CB = ihpq_pkg::CNT_BITS;

   ihpq_pkg::state_type state_ff, state_in;

   // memories
   ihpq_pkg::slot_type heap_mem [ihpq_pkg::SLOT_COUNT];
   logic [PB-1:0]      sot_mem  [ihpq_pkg::SLOT_COUNT];
   ihpq_pkg::slot_type heap_q;
   logic [PB-1:0]      sot_q;
   logic [ihpq_pkg::SLOT_COUNT-1:0] present_ff, present_in;

   logic               heap_we, sot_we;
   logic [PB-1:0]      heap_waddr, heap_raddr, sot_waddr, sot_raddr;
   ihpq_pkg::slot_type heap_wdata;
   logic [PB-1:0]      sot_wdata;

   // working registers
   ihpq_pkg::opcode_type op_ff, op_in;
   logic [7:0]           id_ff, id_in, deg_ff, deg_in;
   logic [CB-1:0]        count_ff, count_in, build_ff, build_in;
   logic [PB-1:0]        pos_ff, pos_in, up_ff, up_in;
   ihpq_pkg::slot_type   cur_ff, cur_in, left_ff, left_in, top_ff, top_in;
   logic                 resift_ff, resift_in;
   ihpq_pkg::status_type status_ff, status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [31:0]          rsp_data_ff, rsp_data_in;

   // family addresses
   logic [PB+1:0] left_pos, right_pos;
   logic [CB-1:0] last_pos;
   ihpq_pkg::family_type fam;
   ihpq_pkg::pick_type   pick;

   assign left_pos  = {1'b0, pos_ff, 1'b1};
   assign right_pos = {1'b0, pos_ff, 1'b0} + (PB+2)'(2);
   assign last_pos  = count_ff - CB'(1);

   function automatic logic [PB-1:0] parent_of(logic [PB-1:0] p);
      logic [PB-1:0] m;
      m = p - PB'(1);
      return {1'b0, m[PB-1:1]};
   endfunction

   function automatic logic [PB-1:0] last_build(logic [CB-1:0] b);
      logic [CB-1:0] m;
      m = b - CB'(1);
      return m[PB-1:0];
   endfunction

   // the shared compare serves both sink and rise
   always_comb begin
      if (state_ff == ihpq_pkg::S_RISE_C) begin
         fam.self     = cur_ff;
         fam.left     = heap_q;
         fam.right    = heap_q;
         fam.left_ok  = 1'b1;
         fam.right_ok = 1'b0;
      end else begin
         fam.self     = cur_ff;
         fam.left     = left_ff;
         fam.right    = heap_q;
         fam.left_ok  = left_pos < {1'b0, count_ff};
         fam.right_ok = right_pos < {1'b0, count_ff};
      end
   end

   ihpq_rank u_rank (.fam(fam), .pick(pick));

   // memory ports
   always_ff @(posedge clock) begin
      if (heap_we) heap_mem[heap_waddr] <= heap_wdata;
      heap_q <= heap_mem[heap_raddr];
   end

   always_ff @(posedge clock) begin
      if (sot_we) sot_mem[sot_waddr] <= sot_wdata;
      sot_q <= sot_mem[sot_raddr];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ihpq_pkg::S_IDLE: begin
            if (req_tvalid) state_in = ihpq_pkg::S_DECODE;
         end
         ihpq_pkg::S_DECODE: begin
            state_in = ihpq_pkg::S_DONE;
            case (op_ff)
               ihpq_pkg::OP_INSERT: begin
                  if (!present_ff[id_ff] && count_ff < CB'(ihpq_pkg::SLOT_COUNT))
                     state_in = ihpq_pkg::S_RISE;
               end
               ihpq_pkg::OP_BUILD: state_in = ihpq_pkg::S_BUILD;
               ihpq_pkg::OP_UPDATE: begin
                  if (present_ff[id_ff]) state_in = ihpq_pkg::S_LOOKUP;
               end
               ihpq_pkg::OP_ERASE, ihpq_pkg::OP_ERASE_LAZY: begin
                  if (count_ff != '0 && present_ff[id_ff]) state_in = ihpq_pkg::S_LOOKUP;
               end
               ihpq_pkg::OP_POP, ihpq_pkg::OP_PEEK: begin
                  if (count_ff != '0) state_in = ihpq_pkg::S_TOP;
               end
               default: state_in = ihpq_pkg::S_DONE;
            endcase
         end
         ihpq_pkg::S_LOOKUP: begin
            state_in = ihpq_pkg::S_DONE;
            if ({1'b0, sot_q} < count_ff) begin
               if (op_ff == ihpq_pkg::OP_UPDATE) state_in = ihpq_pkg::S_UPD_LD;
               else if ({1'b0, sot_q} < last_pos) state_in = ihpq_pkg::S_MOVE_LD;
            end
         end
         ihpq_pkg::S_TOP: begin
            state_in = ihpq_pkg::S_DONE;
            if (op_ff == ihpq_pkg::OP_POP && last_pos != '0) state_in = ihpq_pkg::S_MOVE_LD;
         end
         ihpq_pkg::S_MOVE_LD: begin
            if (op_ff == ihpq_pkg::OP_ERASE_LAZY) state_in = ihpq_pkg::S_DONE;
            else state_in = ihpq_pkg::S_SK_L;
         end
         ihpq_pkg::S_UPD_LD: state_in = ihpq_pkg::S_SK_L;
         ihpq_pkg::S_BUILD: begin
            if (build_ff == '0) state_in = ihpq_pkg::S_DONE;
            else state_in = ihpq_pkg::S_SK_LD;
         end
         ihpq_pkg::S_SK_LD: state_in = ihpq_pkg::S_SK_L;
         ihpq_pkg::S_SK_L:  state_in = ihpq_pkg::S_SK_R;
         ihpq_pkg::S_SK_R:  state_in = ihpq_pkg::S_SK_C;
         ihpq_pkg::S_SK_C: begin
            if (pick != ihpq_pkg::PICK_SELF) state_in = ihpq_pkg::S_SK_L;
            else if (resift_ff) state_in = ihpq_pkg::S_RISE;
            else if (op_ff == ihpq_pkg::OP_BUILD) state_in = ihpq_pkg::S_BUILD;
            else state_in = ihpq_pkg::S_DONE;
         end
         ihpq_pkg::S_RISE: begin
            if (pos_ff == '0) state_in = ihpq_pkg::S_DONE;
            else state_in = ihpq_pkg::S_RISE_C;
         end
         ihpq_pkg::S_RISE_C: begin
            if (pick == ihpq_pkg::PICK_SELF) state_in = ihpq_pkg::S_RISE;
            else state_in = ihpq_pkg::S_DONE;
         end
         ihpq_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) state_in = ihpq_pkg::S_IDLE;
         end
         default: state_in = ihpq_pkg::S_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      op_in        = op_ff;
      id_in        = id_ff;
      deg_in       = deg_ff;
      count_in     = count_ff;
      build_in     = build_ff;
      pos_in       = pos_ff;
      up_in        = up_ff;
      cur_in       = cur_ff;
      left_in      = left_ff;
      top_in       = top_ff;
      resift_in    = resift_ff;
      status_in    = status_ff;
      present_in   = present_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      heap_we      = 1'b0;
      heap_waddr   = pos_ff;
      heap_wdata   = cur_ff;
      heap_raddr   = pos_ff;
      sot_we       = 1'b0;
      sot_waddr    = cur_ff.id;
      sot_wdata    = pos_ff;
      sot_raddr    = id_ff;
      case (state_ff)
         ihpq_pkg::S_IDLE: begin
            op_in     = ihpq_pkg::opcode_type'(req_tdata[2:0]);
            id_in     = req_tdata[10:3];
            deg_in    = req_tdata[18:11];
            status_in = ihpq_pkg::ST_OK;
            top_in    = '0;
         end
         ihpq_pkg::S_DECODE: begin
            case (op_ff)
               ihpq_pkg::OP_INSERT, ihpq_pkg::OP_INSERT_LAZY: begin
                  if (present_ff[id_ff]) begin
                     status_in = ihpq_pkg::ST_PRESENT;
                  end else if (count_ff >= CB'(ihpq_pkg::SLOT_COUNT)) begin
                     status_in = ihpq_pkg::ST_FULL;
                  end else begin
                     count_in           = count_ff + CB'(1);
                     present_in[id_ff]  = 1'b1;
                     pos_in             = count_ff[PB-1:0];
                     cur_in             = {id_ff, deg_ff};
                     heap_we            = 1'b1;
                     heap_waddr         = count_ff[PB-1:0];
                     heap_wdata         = {id_ff, deg_ff};
                     sot_we             = 1'b1;
                     sot_waddr          = id_ff;
                     sot_wdata          = count_ff[PB-1:0];
                  end
               end
               ihpq_pkg::OP_BUILD: build_in = count_ff;
               ihpq_pkg::OP_UPDATE: begin
                  if (!present_ff[id_ff]) status_in = ihpq_pkg::ST_ABSENT;
               end
               ihpq_pkg::OP_ERASE, ihpq_pkg::OP_ERASE_LAZY: begin
                  if (count_ff == '0) status_in = ihpq_pkg::ST_EMPTY;
                  else if (!present_ff[id_ff]) status_in = ihpq_pkg::ST_ABSENT;
               end
               default: begin
                  heap_raddr = '0;
                  if (count_ff == '0) status_in = ihpq_pkg::ST_EMPTY;
               end
            endcase
         end
         ihpq_pkg::S_LOOKUP: begin
            pos_in    = sot_q;
            resift_in = 1'b1;
            if ({1'b0, sot_q} < count_ff) begin
               if (op_ff == ihpq_pkg::OP_UPDATE) begin
                  heap_raddr = sot_q;
               end else begin
                  present_in[id_ff] = 1'b0;
                  count_in          = last_pos;
                  heap_raddr        = last_pos[PB-1:0];
               end
            end
         end
         ihpq_pkg::S_TOP: begin
            top_in    = heap_q;
            pos_in    = '0;
            resift_in = 1'b1;
            if (op_ff == ihpq_pkg::OP_POP) begin
               present_in[heap_q.id] = 1'b0;
               count_in              = last_pos;
               heap_raddr            = last_pos[PB-1:0];
            end
         end
         ihpq_pkg::S_MOVE_LD: begin
            cur_in = heap_q;
            if (op_ff == ihpq_pkg::OP_ERASE_LAZY) begin
               heap_we    = 1'b1;
               heap_wdata = heap_q;
               sot_we     = 1'b1;
               sot_waddr  = heap_q.id;
            end
         end
         ihpq_pkg::S_UPD_LD: cur_in = {heap_q.id, deg_ff};
         ihpq_pkg::S_BUILD: begin
            resift_in = 1'b0;
            if (build_ff != '0) begin
               build_in   = build_ff - CB'(1);
               pos_in     = last_build(build_ff);
               heap_raddr = last_build(build_ff);
            end
         end
         ihpq_pkg::S_SK_LD: cur_in = heap_q;
         ihpq_pkg::S_SK_L:  heap_raddr = left_pos[PB-1:0];
         ihpq_pkg::S_SK_R: begin
            left_in    = heap_q;
            heap_raddr = right_pos[PB-1:0];
         end
         ihpq_pkg::S_SK_C: begin
            if (pick == ihpq_pkg::PICK_LEFT || pick == ihpq_pkg::PICK_RIGHT) begin
               // child moves up into the hole
               heap_we    = 1'b1;
               heap_wdata = (pick == ihpq_pkg::PICK_LEFT) ? left_ff : heap_q;
               sot_we     = 1'b1;
               sot_waddr  = heap_wdata.id;
               pos_in     = (pick == ihpq_pkg::PICK_LEFT) ? left_pos[PB-1:0]
                                                          : right_pos[PB-1:0];
               resift_in  = 1'b0;
            end else if (resift_ff) begin
               resift_in = 1'b0;
            end else begin
               heap_we = 1'b1;
               sot_we  = 1'b1;
            end
         end
         ihpq_pkg::S_RISE: begin
            up_in      = parent_of(pos_ff);
            heap_raddr = parent_of(pos_ff);
            if (pos_ff == '0) begin
               heap_we = 1'b1;
               sot_we  = 1'b1;
            end
         end
         ihpq_pkg::S_RISE_C: begin
            heap_we = 1'b1;
            sot_we  = 1'b1;
            if (pick == ihpq_pkg::PICK_SELF) begin
               // parent moves down, hole goes up
               heap_wdata = heap_q;
               sot_waddr  = heap_q.id;
               pos_in     = up_ff;
            end
         end
         ihpq_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'b0, status_ff, count_ff, top_ff.deg, top_ff.id};
            end
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ihpq_pkg::S_IDLE;
         count_ff     <= '0;
         present_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         resift_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         present_ff   <= present_in;
         rsp_valid_ff <= rsp_valid_in;
         resift_ff    <= resift_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      id_ff       <= id_in;
      deg_ff      <= deg_in;
      build_ff    <= build_in;
      pos_ff      <= pos_in;
      up_ff       <= up_in;
      cur_ff      <= cur_in;
      left_ff     <= left_in;
      top_ff      <= top_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = state_ff == ihpq_pkg::S_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the indexed max-heap priority queue unit.
`timescale 1ns / 1ps

// Heap predictor plus the queue of expected responses.
class heap_scoreboard;
   ihpq_pkg::slot_type slots[ihpq_pkg::SLOT_COUNT];
   logic [7:0] slot_of[256];
   bit         present[256];
   int         held;
   logic [31:0] pending[$];
   int         errors;
   int         checked;

   function void clear();
      held = 0;
      foreach (present[i]) present[i] = 0;
   endfunction

   function bit beats(ihpq_pkg::slot_type a, ihpq_pkg::slot_type b);
      if (a.deg == b.deg) return a.id > b.id;
      return a.deg > b.deg;
   endfunction

   function void put(int pos, ihpq_pkg::slot_type s);
      slots[pos] = s;
      slot_of[s.id] = 8'(pos);
   endfunction

   function int best_child(int pos);
      int l, r, b;
      l = 2 * pos + 1;
      r = 2 * pos + 2;
      b = pos;
      if (l < held && beats(slots[l], slots[b])) b = l;
      if (r < held && beats(slots[r], slots[b])) b = r;
      return b;
   endfunction

   function void sink_slot(int pos);
      int b;
      ihpq_pkg::slot_type t;
      forever begin
         b = best_child(pos);
         if (b == pos) return;
         t = slots[pos];
         put(pos, slots[b]);
         put(b, t);
         pos = b;
      end
   endfunction

   function void sift_up(int pos);
      ihpq_pkg::slot_type s;
      int up;
      s = slots[pos];
      while (pos != 0) begin
         up = (pos - 1) / 2;
         if (!beats(s, slots[up])) break;
         put(pos, slots[up]);
         pos = up;
      end
      put(pos, s);
   endfunction

   function void resift(int pos);
      if (best_child(pos) != pos) sink_slot(pos);
      else sift_up(pos);
   endfunction

   function void remove_slot(int pos, bit ordered);
      int last;
      last = held - 1;
      present[slots[pos].id] = 0;
      held = last;
      if (pos < last) begin
         put(pos, slots[last]);
         if (ordered) resift(pos);
      end
   endfunction

   // note an accepted request and queue its response
   function void note_request(ihpq_pkg::opcode_type op, logic [7:0] id, logic [7:0] deg);
      ihpq_pkg::status_type st;
      logic [7:0] tid, tdeg;
      ihpq_pkg::slot_type s;
      int pos;
      st = ihpq_pkg::ST_OK;
      tid = '0;
      tdeg = '0;
      case (op)
         ihpq_pkg::OP_INSERT, ihpq_pkg::OP_INSERT_LAZY: begin
            if (present[id]) st = ihpq_pkg::ST_PRESENT;
            else if (held >= ihpq_pkg::SLOT_COUNT) st = ihpq_pkg::ST_FULL;
            else begin
               s.id = id;
               s.deg = deg;
               pos = held;
               held++;
               present[id] = 1;
               put(pos, s);
               if (op == ihpq_pkg::OP_INSERT) sift_up(pos);
            end
         end
         ihpq_pkg::OP_BUILD: begin
            for (int i = held - 1; i >= 0; i--) sink_slot(i);
         end
         ihpq_pkg::OP_UPDATE: begin
            if (!present[id]) st = ihpq_pkg::ST_ABSENT;
            else begin
               pos = int'(slot_of[id]);
               if (pos < held) begin
                  slots[pos].deg = deg;
                  resift(pos);
               end
            end
         end
         ihpq_pkg::OP_ERASE, ihpq_pkg::OP_ERASE_LAZY: begin
            if (held == 0) st = ihpq_pkg::ST_EMPTY;
            else if (!present[id]) st = ihpq_pkg::ST_ABSENT;
            else begin
               pos = int'(slot_of[id]);
               if (pos < held) remove_slot(pos, op == ihpq_pkg::OP_ERASE);
            end
         end
         default: begin
            if (held == 0) st = ihpq_pkg::ST_EMPTY;
            else begin
               tid = slots[0].id;
               tdeg = slots[0].deg;
               if (op == ihpq_pkg::OP_POP) remove_slot(0, 1);
            end
         end
      endcase
      pending.insert(pending.size(), {4'd0, st, 9'(held), tdeg, tid});
   endfunction

   task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      if (errors <= 20)
         $display("mismatch %0s: got %h expected %h at %0t", what, got, want, $time);
   endtask

   // check one response beat
   task check_response(logic [31:0] got);
      logic [31:0] want;
      checked++;
      if (pending.size() == 0) begin
         report("unexpected beat", got, '0);
         return;
      end
      want = pending.pop_front();
      if (got[7:0] != want[7:0]) report("top_id", 32'(got[7:0]), 32'(want[7:0]));
      if (got[15:8] != want[15:8]) report("top_degree", 32'(got[15:8]), 32'(want[15:8]));
      if (got[24:16] != want[24:16])
         report("entry_count", 32'(got[24:16]), 32'(want[24:16]));
      if (got[27:25] != want[27:25]) report("status", 32'(got[27:25]), 32'(want[27:25]));
      if (got[31:28] != 4'd0) report("pad bits", got, want);
   endtask
endclass

module testbench;
   localparam int WATCHDOG = 20000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;

   heap_scoreboard sb;
   int  idle_cycles;
   int  sent;
   bit  stall_mode;
   bit  all_sent;
   int  op_seen[8];

   indexed_max_heap_priority_queue_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // mostly short gaps, now and then a long one
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // sample both channels at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            sb.note_request(ihpq_pkg::opcode_type'(req_tdata[2:0]), req_tdata[10:3],
                            req_tdata[18:11]);
            op_seen[req_tdata[2:0]]++;
         end
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
      end
   end

   // response-side back-pressure
   initial begin
      int g;
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         if (stall_mode) begin
            g = gap_len();
            rsp_tready <= 1'b0;
            repeat (g) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(negedge clock);
      end
   end

   task automatic send(ihpq_pkg::opcode_type op, logic [7:0] id, logic [7:0] deg);
      int g;
      g = stall_mode ? gap_len() : 0;
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'd0, deg, id, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      sent++;
   endtask

   task automatic go_quiet();
      req_tvalid <= 1'b0;
      @(negedge clock);
   endtask

   // random 8-bit value
   function automatic logic [7:0] rand8();
      return 8'($urandom_range(0, 255));
   endfunction

   // id of a random held entry, or a random id when empty
   function automatic logic [7:0] held_id();
      int k;
      if (sb.held == 0) return rand8();
      k = $urandom_range(0, sb.held - 1);
      return sb.slots[k].id;
   endfunction

   initial begin
      logic [7:0] id;
      int r;
      sb = new();
      sb.clear();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      stall_mode = 1'b0;
      all_sent = 1'b0;
      sent = 0;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // directed: empty heap cases, extremes, duplicate, each operation
      send(ihpq_pkg::OP_POP, 8'h00, 8'h00);
      send(ihpq_pkg::OP_PEEK, 8'h00, 8'h00);
      send(ihpq_pkg::OP_ERASE, 8'h05, 8'h00);
      send(ihpq_pkg::OP_ERASE_LAZY, 8'h05, 8'h00);
      send(ihpq_pkg::OP_BUILD, 8'h00, 8'h00);
      send(ihpq_pkg::OP_UPDATE, 8'h09, 8'h09);
      send(ihpq_pkg::OP_INSERT, 8'hff, 8'hff);
      send(ihpq_pkg::OP_INSERT, 8'h00, 8'h00);
      send(ihpq_pkg::OP_INSERT, 8'h00, 8'h10);
      send(ihpq_pkg::OP_INSERT_LAZY, 8'h55, 8'hff);
      send(ihpq_pkg::OP_INSERT_LAZY, 8'haa, 8'h55);
      send(ihpq_pkg::OP_PEEK, 8'h00, 8'h00);
      send(ihpq_pkg::OP_BUILD, 8'h00, 8'h00);
      send(ihpq_pkg::OP_PEEK, 8'h00, 8'h00);
      send(ihpq_pkg::OP_UPDATE, 8'h00, 8'hff);
      send(ihpq_pkg::OP_ERASE, 8'h77, 8'h00);
      send(ihpq_pkg::OP_ERASE, 8'haa, 8'h00);
      send(ihpq_pkg::OP_ERASE_LAZY, 8'h00, 8'h00);
      send(ihpq_pkg::OP_POP, 8'h00, 8'h00);
      send(ihpq_pkg::OP_POP, 8'h00, 8'h00);
      send(ihpq_pkg::OP_POP, 8'h00, 8'h00);

      // fill to capacity, insert once more, build, then pop 40 entries
      for (int i = 0; i < 256; i++) send(ihpq_pkg::OP_INSERT_LAZY, 8'(i), rand8());
      send(ihpq_pkg::OP_INSERT, 8'h12, 8'h34);
      send(ihpq_pkg::OP_BUILD, 8'h00, 8'h00);
      for (int i = 0; i < 40; i++) send(ihpq_pkg::OP_POP, 8'h00, 8'h00);

      // random mix with stalls on both sides, paused in some stretches
      stall_mode = 1'b1;
      for (int n = 0; n < 700; n++) begin
         r = $urandom_range(0, 99);
         id = $urandom_range(0, 99) < 70 ? held_id() : rand8();
         if (r < 28) send(ihpq_pkg::OP_INSERT, rand8(), rand8());
         else if (r < 36) send(ihpq_pkg::OP_INSERT_LAZY, rand8(), rand8());
         else if (r < 40) send(ihpq_pkg::OP_BUILD, 8'h00, 8'h00);
         else if (r < 55) send(ihpq_pkg::OP_UPDATE, id, rand8());
         else if (r < 67) send(ihpq_pkg::OP_ERASE, id, rand8());
         else if (r < 72) send(ihpq_pkg::OP_ERASE_LAZY, id, rand8());
         else if (r < 88) send(ihpq_pkg::OP_POP, rand8(), rand8());
         else send(ihpq_pkg::OP_PEEK, rand8(), rand8());
         if (n % 250 == 200) stall_mode = 1'b0;
         if (n % 250 == 249) stall_mode = 1'b1;
      end
      go_quiet();
      all_sent = 1'b1;
   end

   // end of run and watchdog
   initial begin
      @(negedge reset);
      forever begin
         @(negedge clock);
         if (idle_cycles >= WATCHDOG) begin
            $display("watchdog expired with %0d responses pending", sb.pending.size());
            $display("== FAIL ==");
            $finish;
         end
         if (all_sent && sb.pending.size() == 0 && idle_cycles > 40) begin
            $display("%0d requests sent, %0d responses checked, %0d mismatches",
                     sent, sb.checked, sb.errors);
            $display("ops: ins %0d lazy %0d build %0d upd %0d ers %0d lers %0d",
                     op_seen[0], op_seen[1], op_seen[2], op_seen[3],
                     op_seen[4], op_seen[5]);
            $display("     pop %0d peek %0d", op_seen[6], op_seen[7]);
            if (sb.errors == 0) $display("== PASS ==");
            else $display("== FAIL ==");
            $finish;
         end
      end
   end
endmodule
